### rtl/wcs_pkg.sv
// Shared types and constants for the wash cycle sequencer.
`timescale 1ns / 1ps

package wcs_pkg;

	// Register file index width and reset values
	localparam int CFG_IDX_BITS = 3;

	localparam int RST_MOTOR_FILL  = 3000;
	localparam int RST_FILL_LIMIT  = 6000;
	localparam int RST_ULTRASONIC  = 6000;
	localparam int RST_DRAIN_LIMIT = 30000;
	localparam int RST_DRAIN_TAIL  = 10000;
	localparam int RST_CLEAN       = 3753;
	localparam int RST_DIRTY       = 2906;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MOTOR_FILL  = 3'd0,
		CFG_FILL_LIMIT  = 3'd1,
		CFG_ULTRASONIC  = 3'd2,
		CFG_DRAIN_LIMIT = 3'd3,
		CFG_DRAIN_TAIL  = 3'd4,
		CFG_CLEAN       = 3'd5,
		CFG_DIRTY       = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_FILL_MOTOR = 3'd1,
		PH_FILL       = 3'd2,
		PH_WAVE       = 3'd3,
		PH_DRAIN      = 3'd4,
		PH_TAIL       = 3'd5,
		PH_DONE       = 3'd6
	} phase_t;

	// Cycle target: zero means turbidity not yet judged
	localparam logic [1:0] TGT_NONE  = 2'd0;
	localparam logic [1:0] TGT_ONE   = 2'd1;
	localparam logic [1:0] TGT_TWO   = 2'd2;
	localparam logic [1:0] TGT_THREE = 2'd3;

	typedef struct packed {
		logic outlet;
		logic wave;
		logic motor;
		logic inlet;
	} act_t;

	typedef struct packed {
		act_t       act;
		phase_t     phase;
		logic [2:0] cycle_index;
		logic       finished;
	} wcs_result_t;

	// Result tdata: 11 payload bits padded to two bytes
	localparam int OUT_DATA_BITS = 16;

endpackage

### rtl/wcs_cfg_regs.sv
// Configuration register file for the wash cycle sequencer.
`timescale 1ns / 1ps

module wcs_cfg_regs
	import wcs_pkg::*;
#(
	parameter int TIMER_BITS  = 22,
	parameter int SENSOR_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TIMER_BITS-1:0]   cfg_data,
	output logic [TIMER_BITS-1:0]   motor_fill_time,
	output logic [TIMER_BITS-1:0]   fill_limit_time,
	output logic [TIMER_BITS-1:0]   ultrasonic_time,
	output logic [TIMER_BITS-1:0]   drain_limit_time,
	output logic [TIMER_BITS-1:0]   drain_tail_time,
	output logic [SENSOR_BITS-1:0]  clean_threshold,
	output logic [SENSOR_BITS-1:0]  dirty_threshold
);

	logic [TIMER_BITS-1:0]  motor_fill_q, fill_limit_q, ultrasonic_q;
	logic [TIMER_BITS-1:0]  drain_limit_q, drain_tail_q;
	logic [SENSOR_BITS-1:0] clean_q, dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_fill_q  <= TIMER_BITS'(RST_MOTOR_FILL);
			fill_limit_q  <= TIMER_BITS'(RST_FILL_LIMIT);
			ultrasonic_q  <= TIMER_BITS'(RST_ULTRASONIC);
			drain_limit_q <= TIMER_BITS'(RST_DRAIN_LIMIT);
			drain_tail_q  <= TIMER_BITS'(RST_DRAIN_TAIL);
			clean_q       <= SENSOR_BITS'(RST_CLEAN);
			dirty_q       <= SENSOR_BITS'(RST_DIRTY);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MOTOR_FILL:  motor_fill_q  <= cfg_data;
				CFG_FILL_LIMIT:  fill_limit_q  <= cfg_data;
				CFG_ULTRASONIC:  ultrasonic_q  <= cfg_data;
				CFG_DRAIN_LIMIT: drain_limit_q <= cfg_data;
				CFG_DRAIN_TAIL:  drain_tail_q  <= cfg_data;
				CFG_CLEAN:       clean_q       <= cfg_data[SENSOR_BITS-1:0];
				CFG_DIRTY:       dirty_q       <= cfg_data[SENSOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign motor_fill_time  = motor_fill_q;
	assign fill_limit_time  = fill_limit_q;
	assign ultrasonic_time  = ultrasonic_q;
	assign drain_limit_time = drain_limit_q;
	assign drain_tail_time  = drain_tail_q;
	assign clean_threshold  = clean_q;
	assign dirty_threshold  = dirty_q;

endmodule

### rtl/wcs_seq_core.sv
// Sequencer state and per-tick next-state logic.
`timescale 1ns / 1ps

module wcs_seq_core
	import wcs_pkg::*;
#(
	parameter int TIMER_BITS  = 22,
	parameter int SENSOR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic                   start_req,
	input  logic                   door_open,
	input  logic                   water_high,
	input  logic                   water_low,
	input  logic [SENSOR_BITS-1:0] turbidity,
	input  logic [TIMER_BITS-1:0]  motor_fill_time,
	input  logic [TIMER_BITS-1:0]  fill_limit_time,
	input  logic [TIMER_BITS-1:0]  ultrasonic_time,
	input  logic [TIMER_BITS-1:0]  drain_limit_time,
	input  logic [TIMER_BITS-1:0]  drain_tail_time,
	input  logic [SENSOR_BITS-1:0] clean_threshold,
	input  logic [SENSOR_BITS-1:0] dirty_threshold,
	output wcs_result_t            res
);

	phase_t                phase_q, ph;
	act_t                  act_q, act;
	logic [TIMER_BITS-1:0] fill_q, stage_q, ft, st;
	logic [2:0]            cycle_q, cc;
	logic [1:0]            target_q, ct, judged;
	logic                  go, fin;

	// Turbidity judgement: clean gives one cycle, dirty three
	always_comb begin
		if (turbidity > clean_threshold)
			judged = TGT_ONE;
		else if (turbidity < dirty_threshold)
			judged = TGT_THREE;
		else
			judged = TGT_TWO;
	end

	// Phases may chain within one tick; go drops where the sequence stops
	always_comb begin
		ft  = (fill_q == '1) ? fill_q : fill_q + TIMER_BITS'(1);
		st  = (stage_q == '1) ? stage_q : stage_q + TIMER_BITS'(1);
		ph  = phase_q;
		act = act_q;
		cc  = cycle_q;
		ct  = target_q;
		go  = 1'b0;
		fin = 1'b0;

		if (start_req) begin
			ph  = PH_FILL_MOTOR;
			cc  = 3'd1;
			ct  = TGT_NONE;
			act = '0;
		end

		if (!door_open) begin
			go = 1'b1;
			if (ph == PH_FILL_MOTOR && !act.inlet) begin
				act.inlet = 1'b1;
				act.motor = 1'b1;
				ft        = '0;
			end
			if (ph == PH_FILL_MOTOR || ph == PH_FILL) begin
				if (ft < motor_fill_time) begin
					go = 1'b0;
				end else begin
					act.motor = 1'b0;
					ph        = PH_FILL;
					if (ct == TGT_NONE)
						ct = judged;
					if (!(water_high || ft >= fill_limit_time)) begin
						go = 1'b0;
					end else begin
						act.inlet = 1'b0;
						act.wave  = 1'b1;
						st        = '0;
						ph        = PH_WAVE;
					end
				end
			end
			if (go && ph == PH_WAVE) begin
				if (st < ultrasonic_time) begin
					go = 1'b0;
				end else begin
					act.wave   = 1'b0;
					act.outlet = 1'b1;
					st         = '0;
					ph         = PH_DRAIN;
				end
			end
			if (go && ph == PH_DRAIN) begin
				if (!(water_low || st >= drain_limit_time)) begin
					go = 1'b0;
				end else begin
					ft = '0;
					ph = PH_TAIL;
				end
			end
			if (go && ph == PH_TAIL) begin
				if (ft >= drain_tail_time) begin
					act.outlet = 1'b0;
					if (cc < {1'b0, ct}) begin
						cc = cc + 3'd1;
						ph = PH_FILL_MOTOR;
					end else begin
						ph  = PH_DONE;
						fin = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			act_q    <= '0;
			fill_q   <= '0;
			stage_q  <= '0;
			cycle_q  <= '0;
			target_q <= TGT_NONE;
		end else if (tick) begin
			phase_q  <= ph;
			act_q    <= act;
			fill_q   <= ft;
			stage_q  <= st;
			cycle_q  <= cc;
			target_q <= ct;
		end
	end

	assign res.act         = act;
	assign res.phase       = ph;
	assign res.cycle_index = cc;
	assign res.finished    = fin;

endmodule

### rtl/wash_cycle_sequencer.sv
// Wash cycle sequencer top level: stream handshake, result register, assertions.
//
//  port group   dir  tdata bits (low first)
//  s_axis       in   start_req, door_open, water_high, water_low, turbidity
//  m_axis       out  inlet_valve_on, motor_on, ultrasonic_on, outlet_valve_on,
//                    phase[3], cycle_index[3], finished
//  cfg          in   cfg_we, cfg_index, cfg_data (write only)
//
// One tick per clock while the output is not stalled; the result appears in the cycle after the transfer.
// The result register frees as it is taken, so ticks flow back to back.
// A stalled output holds s_axis_tready low until the result is taken.
// arst_n clears the sequence to idle and loads register defaults.
`timescale 1ns / 1ps

module wash_cycle_sequencer
	import wcs_pkg::*;
#(
	parameter int TIMER_BITS  = 22,
	parameter int SENSOR_BITS = 12,
	localparam int IN_DATA_BITS = ((4 + SENSOR_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// start_req, door_open, water_high, water_low, turbidity; zero padded
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// inlet_valve_on, motor_on, ultrasonic_on, outlet_valve_on, phase,
	// cycle_index, finished; zero padded
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [TIMER_BITS-1:0]    cfg_data
);

	logic [TIMER_BITS-1:0]  motor_fill_time, fill_limit_time, ultrasonic_time;
	logic [TIMER_BITS-1:0]  drain_limit_time, drain_tail_time;
	logic [SENSOR_BITS-1:0] clean_threshold, dirty_threshold;
	wcs_result_t            res;
	logic                   in_fire;
	logic                   out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	wcs_cfg_regs #(
		.TIMER_BITS  (TIMER_BITS),
		.SENSOR_BITS (SENSOR_BITS)
	) u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.motor_fill_time  (motor_fill_time),
		.fill_limit_time  (fill_limit_time),
		.ultrasonic_time  (ultrasonic_time),
		.drain_limit_time (drain_limit_time),
		.drain_tail_time  (drain_tail_time),
		.clean_threshold  (clean_threshold),
		.dirty_threshold  (dirty_threshold)
	);

	wcs_seq_core #(
		.TIMER_BITS  (TIMER_BITS),
		.SENSOR_BITS (SENSOR_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (in_fire),
		.start_req        (s_axis_tdata[0]),
		.door_open        (s_axis_tdata[1]),
		.water_high       (s_axis_tdata[2]),
		.water_low        (s_axis_tdata[3]),
		.turbidity        (s_axis_tdata[4 +: SENSOR_BITS]),
		.motor_fill_time  (motor_fill_time),
		.fill_limit_time  (fill_limit_time),
		.ultrasonic_time  (ultrasonic_time),
		.drain_limit_time (drain_limit_time),
		.drain_tail_time  (drain_tail_time),
		.clean_threshold  (clean_threshold),
		.dirty_threshold  (dirty_threshold),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_axis_tready)
			out_valid_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			out_data_q <= {5'd0, res.finished, res.cycle_index, res.phase,
				res.act.outlet, res.act.wave, res.act.motor, res.act.inlet};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// Every accepted tick leaves a result in the register next cycle
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> m_axis_tvalid)
		else $error("tick accepted but no result registered");

	// finished only pulses together with the done phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[10]) |-> (m_axis_tdata[6:4] == PH_DONE))
		else $error("finished outside done phase");

	// motor never runs without the inlet open
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
		else $error("motor on with inlet closed");

	// ultrasonic only in its own phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[6:4] == PH_WAVE))
		else $error("ultrasonic on outside its phase");

	// outlet only open while draining or in the drain tail
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |->
		(m_axis_tdata[6:4] == PH_DRAIN || m_axis_tdata[6:4] == PH_TAIL))
		else $error("outlet open outside drain");
`endif

endmodule
